[hw/rtl/srwb_pkg.sv]
// Shared types, constants and helpers for the selective repeat window buffer.
package srwb_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SIZE_W    = SLOT_W + 1;
    localparam int SEQ_W     = 32;
    localparam int LEN_W     = 16;
    localparam int HANDLE_W  = 32;
    localparam int CFG_W     = 7;
    localparam int DIV_BITS  = 4;
    localparam int MOD_STEPS = SEQ_W / DIV_BITS;
    localparam int CNT_W     = (SIZE_W > $clog2(MOD_STEPS) + 1) ? SIZE_W : $clog2(MOD_STEPS) + 1;
    localparam int RESET_SIZE = 8;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_RR     = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [LEN_W-1:0]    length;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic              load;
        logic              mod_step;
        logic              wr;
        logic              rd;
        logic              rd_sweep;
        logic [SLOT_W-1:0] sweep_idx;
        logic              edge_upd;
        logic              emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SIZE_W-1:0] size;
    } dp_stat_t;

    // Clamp a written window size into the range of slots that exist.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [SIZE_W-1:0] n;
        if (v == '0)
            n = SIZE_W'(1);
        else if (int'(v) > MAX_SLOTS)
            n = SIZE_W'(MAX_SLOTS);
        else
            n = SIZE_W'(v);
        return n;
    endfunction

endpackage

[hw/rtl/srwb_ctrl.sv]
// Controller state machine sequencing the modulo, slot access and receive-ready sweep.
module srwb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  srwb_pkg::dp_stat_t   stat,
    output srwb_pkg::ctrl_cmd_t  cmd,
    output logic                 busy
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MOD       = 3'd1;
    localparam logic [2:0] ST_WRITE     = 3'd2;
    localparam logic [2:0] ST_READ      = 3'd3;
    localparam logic [2:0] ST_SWEEP     = 3'd4;
    localparam logic [2:0] ST_SWEEP_END = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [srwb_pkg::CNT_W-1:0] cnt_reg;
    logic [srwb_pkg::CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.sweep_idx = cnt_reg[srwb_pkg::SLOT_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (cnt_reg == srwb_pkg::CNT_W'(srwb_pkg::MOD_STEPS - 1))
                begin
                    cnt_next = '0;
                    unique case (stat.kind)
                        srwb_pkg::KIND_ADD:    state_next = ST_WRITE;
                        srwb_pkg::KIND_LOOKUP: state_next = ST_READ;
                        srwb_pkg::KIND_RR:     state_next = ST_SWEEP;
                        default:               state_next = ST_FINISH;
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                cmd.wr     = 1'b1;
                state_next = ST_FINISH;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_FINISH;
            end
            ST_SWEEP:
            begin
                // One slot read per cycle; the datapath checks it in the next cycle.
                cmd.rd       = 1'b1;
                cmd.rd_sweep = 1'b1;
                if (cnt_reg == srwb_pkg::CNT_W'(stat.size) - 1'b1)
                begin
                    cnt_next   = '0;
                    state_next = ST_SWEEP_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SWEEP_END:
            begin
                cmd.edge_upd = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[hw/rtl/srwb_datapath.sv]
// Datapath: slot store, valid bits, window edge, serial modulo unit and result registers.
module srwb_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  srwb_pkg::ctrl_cmd_t             cmd,
    output srwb_pkg::dp_stat_t              stat,
    input  logic                            cfg_we,
    input  logic [srwb_pkg::CFG_W-1:0]      cfg_data,
    input  logic [1:0]                      kind,
    input  logic [srwb_pkg::SEQ_W-1:0]      seq_num,
    input  logic [srwb_pkg::LEN_W-1:0]      pdu_length,
    input  logic [srwb_pkg::HANDLE_W-1:0]   pdu_handle,
    input  logic [srwb_pkg::SEQ_W-1:0]      ack_seq,
    input  logic [srwb_pkg::SEQ_W-1:0]      send_seq,
    output logic                            done,
    output logic                            found,
    output logic [srwb_pkg::SEQ_W-1:0]      out_seq,
    output logic [srwb_pkg::LEN_W-1:0]      out_length,
    output logic [srwb_pkg::HANDLE_W-1:0]   out_handle,
    output logic [srwb_pkg::SLOT_W-1:0]     slot_index,
    output logic                            window_open,
    output logic [srwb_pkg::SEQ_W-1:0]      window_low,
    output logic [srwb_pkg::SEQ_W:0]        window_high
);

    srwb_pkg::entry_t mem [srwb_pkg::MAX_SLOTS];
    srwb_pkg::entry_t rd_data_reg;

    logic [srwb_pkg::MAX_SLOTS-1:0] valid_reg;
    logic [srwb_pkg::MAX_SLOTS-1:0] valid_next;
    logic [srwb_pkg::SIZE_W-1:0]    size_reg;
    logic [srwb_pkg::SEQ_W-1:0]     lower_edge_reg;
    logic [srwb_pkg::SEQ_W-1:0]     lower_edge_next;

    logic [1:0]                     kind_reg;
    logic [srwb_pkg::SEQ_W-1:0]     seq_reg;
    logic [srwb_pkg::LEN_W-1:0]     len_reg;
    logic [srwb_pkg::HANDLE_W-1:0]  handle_reg;
    logic [srwb_pkg::SEQ_W-1:0]     ack_reg;
    logic [srwb_pkg::SEQ_W-1:0]     send_reg;

    logic [srwb_pkg::SEQ_W-1:0]     div_reg;
    logic [srwb_pkg::SIZE_W-1:0]    rem_reg;
    logic [srwb_pkg::SIZE_W-1:0]    rem_next;
    logic [srwb_pkg::SLOT_W-1:0]    slot;

    logic                           chk_reg;
    logic [srwb_pkg::SLOT_W-1:0]    chk_idx_reg;
    logic [srwb_pkg::SLOT_W-1:0]    rd_addr;
    logic [srwb_pkg::SEQ_W:0]       high;
    logic                           hit;

    logic                           done_reg;
    logic                           found_reg;
    logic [srwb_pkg::SEQ_W-1:0]     out_seq_reg;
    logic [srwb_pkg::LEN_W-1:0]     out_length_reg;
    logic [srwb_pkg::HANDLE_W-1:0]  out_handle_reg;
    logic [srwb_pkg::SLOT_W-1:0]    slot_index_reg;
    logic                           window_open_reg;
    logic [srwb_pkg::SEQ_W-1:0]     window_low_reg;
    logic [srwb_pkg::SEQ_W:0]       window_high_reg;

    assign stat.kind = kind_reg;
    assign stat.size = size_reg;

    // Restoring remainder, four dividend bits per step.
    always_comb
    begin
        logic [srwb_pkg::SIZE_W-1:0] r;
        r = rem_reg;
        for (int k = 0; k < srwb_pkg::DIV_BITS; k++)
        begin
            r = {r[srwb_pkg::SIZE_W-2:0], div_reg[srwb_pkg::SEQ_W-1-k]};
            if (r >= size_reg)
                r = r - size_reg;
        end
        rem_next = r;
    end

    assign slot    = rem_reg[srwb_pkg::SLOT_W-1:0];
    assign rd_addr = cmd.rd_sweep ? cmd.sweep_idx : slot;
    assign hit     = valid_reg[slot] && (kind_reg == srwb_pkg::KIND_LOOKUP);
    assign high    = {1'b0, lower_edge_reg} + (srwb_pkg::SEQ_W + 1)'(size_reg);

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.wr)
            valid_next[slot] = 1'b1;
        if (chk_reg && valid_reg[chk_idx_reg] && (rd_data_reg.seq < ack_reg))
            valid_next[chk_idx_reg] = 1'b0;
    end

    always_comb
    begin
        lower_edge_next = lower_edge_reg;
        if (cmd.edge_upd && (lower_edge_reg < ack_reg))
            lower_edge_next = ack_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            mem[slot] <= '{seq: seq_reg, length: len_reg, handle: handle_reg};
        if (cmd.rd)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            seq_reg    <= seq_num;
            len_reg    <= pdu_length;
            handle_reg <= pdu_handle;
            ack_reg    <= ack_seq;
            send_reg   <= send_seq;
            div_reg    <= seq_num;
            rem_reg    <= '0;
        end
        else if (cmd.mod_step)
        begin
            div_reg <= div_reg << srwb_pkg::DIV_BITS;
            rem_reg <= rem_next;
        end
        chk_idx_reg <= cmd.sweep_idx;
        if (cmd.emit)
        begin
            found_reg       <= hit;
            out_seq_reg     <= hit ? rd_data_reg.seq : '0;
            out_length_reg  <= hit ? rd_data_reg.length : '0;
            out_handle_reg  <= hit ? rd_data_reg.handle : '0;
            slot_index_reg  <= ((kind_reg == srwb_pkg::KIND_ADD) ||
                                (kind_reg == srwb_pkg::KIND_LOOKUP)) ? slot : '0;
            window_open_reg <= (kind_reg == srwb_pkg::KIND_STATUS) &&
                               (high > {1'b0, send_reg});
            window_low_reg  <= lower_edge_reg;
            window_high_reg <= high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            size_reg       <= srwb_pkg::SIZE_W'(srwb_pkg::RESET_SIZE);
            lower_edge_reg <= '0;
            chk_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            lower_edge_reg <= lower_edge_next;
            chk_reg        <= cmd.rd_sweep;
            done_reg       <= cmd.emit;
            if (cfg_we)
                size_reg <= srwb_pkg::eff_size(cfg_data);
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign out_seq     = out_seq_reg;
    assign out_length  = out_length_reg;
    assign out_handle  = out_handle_reg;
    assign slot_index  = slot_index_reg;
    assign window_open = window_open_reg;
    assign window_low  = window_low_reg;
    assign window_high = window_high_reg;

`ifndef SYNTHESIS
    // A result is shown for a single cycle only.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    // The computed slot always lies inside the window in use.
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr || (cmd.emit && kind_reg == srwb_pkg::KIND_LOOKUP)) |-> (rem_reg < size_reg))
        else $error("slot index outside the window");

    // The lower window edge never moves down.
    a_edge_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.edge_upd |=> (lower_edge_reg >= $past(lower_edge_reg)))
        else $error("lower window edge decreased");

    // A reported hit always carries a slot index taken from the lookup.
    a_found_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && hit) |=> (found_reg && slot_index_reg == $past(slot)))
        else $error("lookup hit reported with wrong slot");
`endif

endmodule

[hw/rtl/selective_repeat_window_buffer_top.sv]
// Top level of the selective repeat window buffer: controller plus datapath.
//
// Each command is taken when start is high and busy is low, and gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall, so sample it then. The
// sequence number is reduced modulo the window size by a serial remainder unit that retires
// four bits a cycle, for every command. After that an add writes the slot, a lookup reads
// it, a status query does neither, and a receive-ready sweeps the slots in use through the
// store's single read port, one slot a cycle, then closes by updating the window edge. A
// final state forms the result; done follows in the cycle busy drops, when the next
// command may enter. Window size writes are taken while busy is low and clamp to 1..64.
module selective_repeat_window_buffer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srwb_pkg::CFG_W-1:0]      cfg_data,
    input  logic [1:0]                      kind,
    input  logic [srwb_pkg::SEQ_W-1:0]      seq_num,
    input  logic [srwb_pkg::LEN_W-1:0]      pdu_length,
    input  logic [srwb_pkg::HANDLE_W-1:0]   pdu_handle,
    input  logic [srwb_pkg::SEQ_W-1:0]      ack_seq,
    input  logic [srwb_pkg::SEQ_W-1:0]      send_seq,
    output logic                            done,
    output logic                            found,
    output logic [srwb_pkg::SEQ_W-1:0]      out_seq,
    output logic [srwb_pkg::LEN_W-1:0]      out_length,
    output logic [srwb_pkg::HANDLE_W-1:0]   out_handle,
    output logic [srwb_pkg::SLOT_W-1:0]     slot_index,
    output logic                            window_open,
    output logic [srwb_pkg::SEQ_W-1:0]      window_low,
    output logic [srwb_pkg::SEQ_W:0]        window_high
);

    srwb_pkg::ctrl_cmd_t cmd;
    srwb_pkg::dp_stat_t  stat;

    assign cfg_ready = !busy;

    srwb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    srwb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .seq_num     (seq_num),
        .pdu_length  (pdu_length),
        .pdu_handle  (pdu_handle),
        .ack_seq     (ack_seq),
        .send_seq    (send_seq),
        .done        (done),
        .found       (found),
        .out_seq     (out_seq),
        .out_length  (out_length),
        .out_handle  (out_handle),
        .slot_index  (slot_index),
        .window_open (window_open),
        .window_low  (window_low),
        .window_high (window_high)
    );

endmodule

[tb/selective_repeat_window_buffer_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the selective repeat window buffer top level.
module selective_repeat_window_buffer_top_tb;

    localparam int CMP_W = srwb_pkg::SEQ_W + 1;

    typedef struct packed {
        logic                          found;
        logic [srwb_pkg::SEQ_W-1:0]    seq;
        logic [srwb_pkg::LEN_W-1:0]    len;
        logic [srwb_pkg::HANDLE_W-1:0] hnd;
        logic [srwb_pkg::SLOT_W-1:0]   slot_index;
        logic                          window_open;
        logic [srwb_pkg::SEQ_W-1:0]    window_low;
        logic [srwb_pkg::SEQ_W:0]      window_high;
    } window_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [srwb_pkg::CFG_W-1:0]      cfg_data;
    logic [1:0]                      kind;
    logic [srwb_pkg::SEQ_W-1:0]      seq_num;
    logic [srwb_pkg::LEN_W-1:0]      pdu_length;
    logic [srwb_pkg::HANDLE_W-1:0]   pdu_handle;
    logic [srwb_pkg::SEQ_W-1:0]      ack_seq;
    logic [srwb_pkg::SEQ_W-1:0]      send_seq;
    logic                            done;
    logic                            found;
    logic [srwb_pkg::SEQ_W-1:0]      out_seq;
    logic [srwb_pkg::LEN_W-1:0]      out_length;
    logic [srwb_pkg::HANDLE_W-1:0]   out_handle;
    logic [srwb_pkg::SLOT_W-1:0]     slot_index;
    logic                            window_open;
    logic [srwb_pkg::SEQ_W-1:0]      window_low;
    logic [srwb_pkg::SEQ_W:0]        window_high;

    // Predicted copy of the slot store, the window edge and the size register.
    logic                            slot_live [srwb_pkg::MAX_SLOTS];
    logic [srwb_pkg::SEQ_W-1:0]      slot_seq_q [srwb_pkg::MAX_SLOTS];
    logic [srwb_pkg::LEN_W-1:0]      slot_len_q [srwb_pkg::MAX_SLOTS];
    logic [srwb_pkg::HANDLE_W-1:0]   slot_hnd_q [srwb_pkg::MAX_SLOTS];
    logic [srwb_pkg::SEQ_W-1:0]      edge_low;
    logic [srwb_pkg::CFG_W-1:0]      win_cfg;

    window_result_t                  pending_results [$];
    logic [srwb_pkg::SEQ_W-1:0]      tx_next;
    bit                              start_held;
    bit                              burst;
    int                              errors;
    int                              results_checked;
    int                              kind_count [4];
    int                              lookup_hits;
    int                              windows_written;

    selective_repeat_window_buffer_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .seq_num     (seq_num),
        .pdu_length  (pdu_length),
        .pdu_handle  (pdu_handle),
        .ack_seq     (ack_seq),
        .send_seq    (send_seq),
        .done        (done),
        .found       (found),
        .out_seq     (out_seq),
        .out_length  (out_length),
        .out_handle  (out_handle),
        .slot_index  (slot_index),
        .window_open (window_open),
        .window_low  (window_low),
        .window_high (window_high)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic logic [srwb_pkg::SEQ_W-1:0] active_slots();
        logic [srwb_pkg::SEQ_W-1:0] n;
        n = srwb_pkg::SEQ_W'(win_cfg);
        if (n == 0)
            n = 1;
        if (n > srwb_pkg::MAX_SLOTS)
            n = srwb_pkg::MAX_SLOTS;
        return n;
    endfunction

    // Applies one command to the predicted state and returns the result it must give.
    function automatic window_result_t predict_item(
        input logic [1:0]                    k,
        input logic [srwb_pkg::SEQ_W-1:0]    seq,
        input logic [srwb_pkg::LEN_W-1:0]    len,
        input logic [srwb_pkg::HANDLE_W-1:0] hnd,
        input logic [srwb_pkg::SEQ_W-1:0]    ack,
        input logic [srwb_pkg::SEQ_W-1:0]    snd);
        window_result_t              r;
        logic [srwb_pkg::SEQ_W-1:0]  n;
        logic [srwb_pkg::SEQ_W-1:0]  slot;
        logic [srwb_pkg::SLOT_W-1:0] idx;
        r = '0;
        n = active_slots();
        slot = seq % n;
        idx = slot[srwb_pkg::SLOT_W-1:0];
        if (k == srwb_pkg::KIND_ADD)
        begin
            slot_live[idx] = 1'b1;
            slot_seq_q[idx] = seq;
            slot_len_q[idx] = len;
            slot_hnd_q[idx] = hnd;
            r.slot_index = idx;
        end
        else if (k == srwb_pkg::KIND_RR)
        begin
            // Only the slots in use are swept; the rest keep their contents.
            for (int i = 0; i < n; i++)
                if (slot_live[i] && slot_seq_q[i] < ack)
                    slot_live[i] = 1'b0;
            if (edge_low < ack)
                edge_low = ack;
        end
        else if (k == srwb_pkg::KIND_LOOKUP)
        begin
            r.slot_index = idx;
            if (slot_live[idx])
            begin
                r.found = 1'b1;
                r.seq = slot_seq_q[idx];
                r.len = slot_len_q[idx];
                r.hnd = slot_hnd_q[idx];
                lookup_hits++;
            end
        end
        r.window_low = edge_low;
        r.window_high = {1'b0, edge_low} + {1'b0, n};
        if (k == srwb_pkg::KIND_STATUS)
            r.window_open = (r.window_high > {1'b0, snd});
        return r;
    endfunction

    task automatic send_item(input logic [1:0]                    k,
                             input logic [srwb_pkg::SEQ_W-1:0]    seq,
                             input logic [srwb_pkg::LEN_W-1:0]    len,
                             input logic [srwb_pkg::HANDLE_W-1:0] hnd,
                             input logic [srwb_pkg::SEQ_W-1:0]    ack,
                             input logic [srwb_pkg::SEQ_W-1:0]    snd);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            if (start_held)
            begin
                start <= 1'b0;
                start_held = 1'b0;
            end
            // Half the gaps count from the previous transfer, half from the block going idle.
            if ($urandom_range(0, 1) == 1)
                do @(posedge clk); while (busy);
            repeat (gap) @(posedge clk);
        end
        kind       <= k;
        seq_num    <= seq;
        pdu_length <= len;
        pdu_handle <= hnd;
        ack_seq    <= ack;
        send_seq   <= snd;
        start      <= 1'b1;
        start_held = 1'b1;
        do @(posedge clk); while (busy);
        pending_results.push_back(predict_item(k, seq, len, hnd, ack, snd));
        kind_count[k]++;
    endtask

    task automatic wait_all_results();
        if (start_held)
        begin
            start <= 1'b0;
            start_held = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_window(input logic [srwb_pkg::CFG_W-1:0] v);
        wait_all_results();
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_cfg = v;
        windows_written++;
    endtask

    task automatic compare_field(input string name, input logic [CMP_W-1:0] want,
                                 input logic [CMP_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n && done)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no command outstanding, window_low %h",
                         $time, window_low);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("found", CMP_W'(want.found), CMP_W'(found));
                compare_field("out_seq", CMP_W'(want.seq), CMP_W'(out_seq));
                compare_field("out_length", CMP_W'(want.len), CMP_W'(out_length));
                compare_field("out_handle", CMP_W'(want.hnd), CMP_W'(out_handle));
                compare_field("slot_index", CMP_W'(want.slot_index), CMP_W'(slot_index));
                compare_field("window_open", CMP_W'(want.window_open), CMP_W'(window_open));
                compare_field("window_low", CMP_W'(want.window_low), CMP_W'(window_low));
                compare_field("window_high", want.window_high, window_high);
            end
        end
    end

    // Right after reset every slot is empty: status shows the reset size, a lookup
    // misses and a receive-ready only moves the edge.
    task automatic test_reset_defaults();
        send_item(srwb_pkg::KIND_STATUS, $urandom, 16'h0, $urandom, $urandom, 32'd7);
        send_item(srwb_pkg::KIND_STATUS, $urandom, 16'h0, $urandom, $urandom, 32'd8);
        send_item(srwb_pkg::KIND_LOOKUP, 32'd3, 16'h0, 32'h0, 32'h0, 32'h0);
        send_item(srwb_pkg::KIND_RR, $urandom, 16'h0, $urandom, 32'd5, $urandom);
    endtask

    // Writes every slot once with the full window in use.
    task automatic test_fill_slots();
        set_window(srwb_pkg::CFG_W'(64));
        for (int i = 0; i < srwb_pkg::MAX_SLOTS; i++)
            send_item(srwb_pkg::KIND_ADD, srwb_pkg::SEQ_W'(i),
                      srwb_pkg::LEN_W'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic test_add_lookup_extremes();
        send_item(srwb_pkg::KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_item(srwb_pkg::KIND_ADD, 32'h0, 16'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(srwb_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0, 32'h0, 32'h0, 32'h0);
        send_item(srwb_pkg::KIND_LOOKUP, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_item(srwb_pkg::KIND_LOOKUP, 32'd64, 16'h0, 32'h0, 32'h0, 32'h0);
    endtask

    // The edge rises to the acknowledgement, never falls; a cleared slot reads back empty.
    task automatic test_receive_ready();
        send_item(srwb_pkg::KIND_RR, $urandom, 16'h0, $urandom, 32'd40, $urandom);
        send_item(srwb_pkg::KIND_LOOKUP, 32'd10, 16'h0, 32'h0, 32'h0, 32'h0);
        send_item(srwb_pkg::KIND_LOOKUP, 32'd45, 16'h0, 32'h0, 32'h0, 32'h0);
        send_item(srwb_pkg::KIND_RR, $urandom, 16'h0, $urandom, 32'd20, $urandom);
        send_item(srwb_pkg::KIND_RR, $urandom, 16'h0, $urandom, 32'd0, $urandom);
    endtask

    task automatic test_status_query();
        send_item(srwb_pkg::KIND_STATUS, 32'h0, 16'h0, 32'h0, 32'h0, 32'd103);
        send_item(srwb_pkg::KIND_STATUS, 32'h0, 16'h0, 32'h0, 32'h0, 32'd104);
        send_item(srwb_pkg::KIND_STATUS, 32'h0, 16'h0, 32'h0, 32'h0, 32'h0);
        send_item(srwb_pkg::KIND_STATUS, 32'h0, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    endtask

    // Zero acts as one slot, values past the store as the full store, and slots
    // outside a smaller window survive a receive-ready.
    task automatic test_size_clamp();
        set_window(srwb_pkg::CFG_W'(0));
        send_item(srwb_pkg::KIND_ADD, 32'd7, 16'h1234, 32'hA5A5_0001, 32'h0, 32'h0);
        send_item(srwb_pkg::KIND_LOOKUP, 32'd12345, 16'h0, 32'h0, 32'h0, 32'h0);
        send_item(srwb_pkg::KIND_STATUS, 32'h0, 16'h0, 32'h0, 32'h0, edge_low);
        set_window(srwb_pkg::CFG_W'(127));
        send_item(srwb_pkg::KIND_LOOKUP, 32'd63, 16'h0, 32'h0, 32'h0, 32'h0);
        send_item(srwb_pkg::KIND_STATUS, 32'h0, 16'h0, 32'h0, 32'h0, edge_low + 32'd64);
        set_window(srwb_pkg::CFG_W'(4));
        send_item(srwb_pkg::KIND_RR, 32'h0, 16'h0, 32'h0, 32'd50, 32'h0);
        set_window(srwb_pkg::CFG_W'(64));
        send_item(srwb_pkg::KIND_LOOKUP, 32'd45, 16'h0, 32'h0, 32'h0, 32'h0);
        send_item(srwb_pkg::KIND_LOOKUP, 32'd2, 16'h0, 32'h0, 32'h0, 32'h0);
    endtask

    // Mostly an orderly sender: new adds, retransmits, acknowledgements inside the
    // outstanding range, lookups and status queries near the window edges.
    task automatic run_traffic(input int unsigned count);
        logic [srwb_pkg::SEQ_W-1:0]    n;
        logic [srwb_pkg::SEQ_W-1:0]    span;
        logic [srwb_pkg::SEQ_W-1:0]    seq;
        logic [srwb_pkg::LEN_W-1:0]    len;
        logic [srwb_pkg::HANDLE_W-1:0] hnd;
        logic [srwb_pkg::SEQ_W-1:0]    ack;
        logic [srwb_pkg::SEQ_W-1:0]    snd;
        int unsigned                   pick;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            n = active_slots();
            if (tx_next - edge_low > 32'h8000_0000)
                tx_next = edge_low;
            span = tx_next - edge_low;
            seq  = $urandom;
            len  = srwb_pkg::LEN_W'($urandom_range(0, 65535));
            hnd  = $urandom;
            ack  = $urandom;
            snd  = $urandom;
            pick = $urandom_range(0, 99);
            if (span > 2 * n || pick < 15)
            begin
                if ($urandom_range(0, 4) != 0)
                    ack = edge_low + $urandom_range(0, span + 1);
                else
                    ack = edge_low - $urandom_range(0, 3 * n);
                send_item(srwb_pkg::KIND_RR, seq, len, hnd, ack, snd);
            end
            else if (pick < 50)
            begin
                if ($urandom_range(0, 4) != 0 || span == 0)
                begin
                    seq = tx_next;
                    tx_next = tx_next + 1;
                end
                else
                    seq = edge_low + $urandom_range(0, span - 1);
                send_item(srwb_pkg::KIND_ADD, seq, len, hnd, ack, snd);
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 4) != 0)
                    seq = edge_low + $urandom_range(0, span + n) - 32'd1;
                send_item(srwb_pkg::KIND_LOOKUP, seq, len, hnd, ack, snd);
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                    snd = edge_low + n + $urandom_range(0, 4) - 32'd2;
                send_item(srwb_pkg::KIND_STATUS, seq, len, hnd, ack, snd);
            end
        end
    endtask

    task automatic test_random_traffic();
        tx_next = edge_low;
        set_window(srwb_pkg::CFG_W'(8));
        run_traffic(280);
        set_window(srwb_pkg::CFG_W'(1));
        run_traffic(150);
        set_window(srwb_pkg::CFG_W'(64));
        run_traffic(280);
        set_window(srwb_pkg::CFG_W'(0));
        run_traffic(80);
        set_window(srwb_pkg::CFG_W'(127));
        run_traffic(100);
        set_window(srwb_pkg::CFG_W'(37));
        run_traffic(260);
        // Move the window close to the top so sequence numbers wrap past zero.
        set_window(srwb_pkg::CFG_W'(16));
        send_item(srwb_pkg::KIND_RR, $urandom, 16'h0, $urandom, 32'hFFFF_FF80, $urandom);
        tx_next = edge_low;
        run_traffic(250);
        burst = 1'b0;
    endtask

    // The highest possible edge carries the upper edge into bit 32.
    task automatic test_edge_limit();
        set_window(srwb_pkg::CFG_W'(64));
        send_item(srwb_pkg::KIND_RR, 32'h0, 16'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_item(srwb_pkg::KIND_STATUS, 32'h0, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(srwb_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0, 32'h0, 32'h0, 32'h0);
        send_item(srwb_pkg::KIND_LOOKUP, 32'h0, 16'h0, 32'h0, 32'h0, 32'h0);
    endtask

    initial
    begin
        for (int i = 0; i < srwb_pkg::MAX_SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_seq_q[i] = '0;
            slot_len_q[i] = '0;
            slot_hnd_q[i] = '0;
        end
        edge_low = '0;
        win_cfg = srwb_pkg::CFG_W'(srwb_pkg::RESET_SIZE);
        tx_next = '0;
        start_held = 1'b0;
        burst = 1'b0;
        errors = 0;
        results_checked = 0;
        lookup_hits = 0;
        windows_written = 0;
        for (int i = 0; i < 4; i++)
            kind_count[i] = 0;

        rst_n      <= 1'b0;
        start      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        kind       <= srwb_pkg::KIND_ADD;
        seq_num    <= '0;
        pdu_length <= '0;
        pdu_handle <= '0;
        ack_seq    <= '0;
        send_seq   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_fill_slots();
        test_add_lookup_extremes();
        test_receive_ready();
        test_status_query();
        test_size_clamp();
        test_random_traffic();
        test_edge_limit();

        wait_all_results();
        repeat (20) @(posedge clk);

        $display("Checked %0d results: %0d adds, %0d receive-readys, %0d lookups (%0d hits),",
                 results_checked, kind_count[srwb_pkg::KIND_ADD],
                 kind_count[srwb_pkg::KIND_RR], kind_count[srwb_pkg::KIND_LOOKUP],
                 lookup_hits);
        $display("%0d status queries, %0d window size writes, %0d mismatches.",
                 kind_count[srwb_pkg::KIND_STATUS], windows_written, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
